### rtl/btld_pkg.sv
// ----------------------------------------------------------------------------
// btld_pkg: shared types and constants of the bencode tag list decoder
// Parse phases, event and fault codes, the event record and the small
// arithmetic helpers used by the parser and the result queue.
// ----------------------------------------------------------------------------
package btld_pkg;

   // Character codes recognized by the parser
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   // Event codes on the result channel
   localparam logic [1:0] EV_START = 2'd0;
   localparam logic [1:0] EV_BYTE  = 2'd1;
   localparam logic [1:0] EV_DONE  = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   // Fault kinds reported with an error event
   localparam logic [2:0] FAULT_DICT_BEGIN = 3'd0;
   localparam logic [2:0] FAULT_INTEGER    = 3'd1;
   localparam logic [2:0] FAULT_LIST_BEGIN = 3'd2;
   localparam logic [2:0] FAULT_STRING     = 3'd3;
   localparam logic [2:0] FAULT_LIST_END   = 3'd4;
   localparam logic [2:0] FAULT_DICT_END   = 3'd5;

   // Result queue geometry: two slots must be free to take a byte
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      PH_EXPECT_D  = 7'b0000001,
      PH_DICT_BODY = 7'b0000010,
      PH_TAG       = 7'b0000100,
      PH_LIST_OPEN = 7'b0001000,
      PH_LIST_BODY = 7'b0010000,
      PH_PAYLOAD   = 7'b0100000,
      PH_DRAIN     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [31:0] entry_tag;
      logic [31:0] string_length;
      logic [7:0]  payload_byte;
      logic        string_done;
      logic [31:0] bytes_used;
      logic [2:0]  fault_kind;
   } event_type;

   // Up to two events per input byte; the second one only follows a first
   typedef struct packed {
      logic      first_valid;
      logic      second_valid;
      event_type first;
      event_type second;
   } parse_out_type;

   function automatic event_type make_error(input logic [2:0] kind);
      event_type ev;
      ev            = '0;
      ev.event_res  = EV_ERROR;
      ev.fault_kind = kind;
      return ev;
   endfunction

   // acc * 10 + digit, modulo 2^32, as two shifts and adds
   function automatic logic [31:0] add_digit(input logic [31:0] acc,
                                             input logic [7:0]  c);
      logic [7:0] d;
      d = c - CHAR_ZERO;
      return (acc << 3) + (acc << 1) + {24'd0, d};
   endfunction

endpackage

### rtl/btld_parser.sv
// ----------------------------------------------------------------------------
// btld_parser: byte-level parse state and event generation
// Advances the parse state once per accepted byte and builds, in the cycle the
// byte is accepted, the events (none, one or two) that the byte causes.
// ----------------------------------------------------------------------------
module btld_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_in,
   input  logic                   buffer_end,
   output btld_pkg::parse_out_type evt
);
   import btld_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] count_ff, count_in;
   logic        seen_ff, seen_in;
   logic        finished;
   logic        is_digit;
   logic [31:0] left_dec;

   assign is_digit = (data_in >= CHAR_ZERO) && (data_in <= CHAR_NINE);
   assign left_dec = left_ff - 32'd1;

   // Decode one byte against the current phase
   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      length_in = length_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      finished  = 1'b0;
      evt       = '0;
      if (accept) begin
         if (phase_ff != PH_DRAIN && phase_ff != PH_EXPECT_D) begin
            count_in = count_ff + 32'd1;
         end
         unique case (phase_ff)
            PH_EXPECT_D: begin
               count_in = 32'd1;
               if (data_in != CHAR_D || buffer_end) begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_DICT_BEGIN);
                  finished        = 1'b1;
               end else begin
                  phase_in = PH_DICT_BODY;
               end
            end
            PH_DICT_BODY: begin
               if (data_in == CHAR_E) begin
                  evt.first_valid          = 1'b1;
                  evt.first.event_res      = EV_DONE;
                  evt.first.bytes_used     = count_in;
                  finished                 = 1'b1;
               end else if (data_in != CHAR_I || buffer_end) begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_INTEGER);
                  finished        = 1'b1;
               end else begin
                  tag_in   = '0;
                  phase_in = PH_TAG;
               end
            end
            PH_TAG: begin
               if (is_digit && !buffer_end) begin
                  tag_in = add_digit(tag_ff, data_in);
               end else if (data_in == CHAR_E) begin
                  if (buffer_end) begin
                     evt.first_valid = 1'b1;
                     evt.first       = make_error(FAULT_LIST_BEGIN);
                     finished        = 1'b1;
                  end else begin
                     phase_in = PH_LIST_OPEN;
                  end
               end else begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_INTEGER);
                  finished        = 1'b1;
               end
            end
            PH_LIST_OPEN: begin
               if (data_in != CHAR_L) begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_LIST_BEGIN);
                  finished        = 1'b1;
               end else if (buffer_end) begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_LIST_END);
                  finished        = 1'b1;
               end else begin
                  length_in = '0;
                  seen_in   = 1'b0;
                  phase_in  = PH_LIST_BODY;
               end
            end
            PH_LIST_BODY: begin
               if (data_in == CHAR_E && !seen_ff) begin
                  if (buffer_end) begin
                     evt.first_valid = 1'b1;
                     evt.first       = make_error(FAULT_DICT_END);
                     finished        = 1'b1;
                  end else begin
                     phase_in = PH_DICT_BODY;
                  end
               end else if (is_digit && !buffer_end) begin
                  length_in = add_digit(length_ff, data_in);
                  seen_in   = 1'b1;
               end else if (data_in == CHAR_COLON) begin
                  // Report the string start; a non-empty string then opens the payload unless the buffer ends
                  evt.first_valid         = 1'b1;
                  evt.first.event_res     = EV_START;
                  evt.first.entry_tag     = tag_ff;
                  evt.first.string_length = length_ff;
                  evt.first.string_done   = (length_ff == '0);
                  length_in               = '0;
                  seen_in                 = 1'b0;
                  if (length_ff == '0) begin
                     if (buffer_end) begin
                        evt.second_valid = 1'b1;
                        evt.second       = make_error(FAULT_LIST_END);
                        finished         = 1'b1;
                     end
                  end else if (buffer_end) begin
                     evt.second_valid = 1'b1;
                     evt.second       = make_error(FAULT_STRING);
                     finished         = 1'b1;
                  end else begin
                     left_in  = length_ff;
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  evt.first_valid = 1'b1;
                  evt.first       = make_error(FAULT_STRING);
                  finished        = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               left_in                = left_dec;
               evt.first_valid        = 1'b1;
               evt.first.event_res    = EV_BYTE;
               evt.first.entry_tag    = tag_ff;
               evt.first.payload_byte = data_in;
               evt.first.string_done  = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_LIST_BODY;
                  if (buffer_end) begin
                     evt.second_valid = 1'b1;
                     evt.second       = make_error(FAULT_LIST_END);
                     finished         = 1'b1;
                  end
               end else if (buffer_end) begin
                  evt.second_valid = 1'b1;
                  evt.second       = make_error(FAULT_STRING);
                  finished         = 1'b1;
               end
            end
            PH_DRAIN: begin
               if (buffer_end) begin
                  phase_in = PH_EXPECT_D;
               end
            end
            default: begin
               phase_in = PH_EXPECT_D;
            end
         endcase
         // Close out the buffer after completion or error
         if (finished) begin
            phase_in  = buffer_end ? PH_EXPECT_D : PH_DRAIN;
            tag_in    = '0;
            length_in = '0;
            left_in   = '0;
            seen_in   = 1'b0;
         end
      end
   end

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_EXPECT_D;
         tag_ff    <= '0;
         length_ff <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
         seen_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && finished && buffer_end |=> phase_ff == PH_EXPECT_D)
      else $error("buffer end after a final event did not rearm the parser");

   a_drain_after_finish: assert property (@(posedge clock) disable iff (reset)
      accept && finished && !buffer_end |=> phase_ff == PH_DRAIN)
      else $error("parser did not drain after completion or error");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

endmodule

### rtl/btld_event_queue.sv
// ----------------------------------------------------------------------------
// btld_event_queue: small in-order queue of result events
// Takes up to two events per cycle from the parser and presents one event
// per transaction at its head.
// ----------------------------------------------------------------------------
module btld_event_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  btld_pkg::parse_out_type evt,
   output logic                    full,
   output logic                    head_valid,
   input  logic                    head_stall,
   output btld_pkg::event_type     head
);
   import btld_pkg::*;

   event_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]       count_ff, count_in;
   logic [QUEUE_AW-1:0]       wr_ptr_next;
   logic                      pop;

   assign head_valid  = (count_ff != '0);
   assign head        = slot_ff[rd_ptr_ff];
   assign pop         = head_valid && !head_stall;
   assign full        = (count_ff > QUEUE_CW'(QUEUE_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + QUEUE_AW'(1);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(evt.first_valid) + QUEUE_AW'(evt.second_valid);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + QUEUE_CW'(evt.first_valid) + QUEUE_CW'(evt.second_valid)
                  - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming events in order
   always_ff @(posedge clock) begin
      if (evt.first_valid) begin
         slot_ff[wr_ptr_ff] <= evt.first;
      end
      if (evt.second_valid) begin
         slot_ff[wr_ptr_next] <= evt.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("event queue overflow");

   a_second_follows_first: assert property (@(posedge clock) disable iff (reset)
      evt.second_valid |-> evt.first_valid)
      else $error("second event without a first");

   a_room_for_push: assert property (@(posedge clock) disable iff (reset)
      evt.first_valid |-> count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2))
      else $error("events pushed without room for two");

endmodule

### rtl/bencode_tag_list_decoder.sv
// ----------------------------------------------------------------------------
// bencode_tag_list_decoder: streaming checker for tagged string lists
// Parses d (i<tag>e l (<len>:<bytes>)* e)* e one byte per transaction and
// reports string starts, payload bytes, completion and errors.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    data_in, buffer_end
//   rsp_     out        rsp_valid/stall    event, tag, length, byte, done,
//                                          bytes used, fault kind
//
// One byte is accepted per cycle while req_stall is low; its events leave the
// result queue one per cycle while rsp_stall is low, so a byte that causes two
// events (a final byte or string start followed by an error) sends them in turn.
// A byte's events are registered in the result queue before they reach rsp_.
// req_stall rises while the four-entry result queue holds three or more events.
// Synchronous reset returns the parser to expecting the opening d.
// ----------------------------------------------------------------------------
module bencode_tag_list_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_in,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [31:0] rsp_entry_tag,
   output logic [31:0] rsp_string_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_string_done,
   output logic [31:0] rsp_bytes_used,
   output logic [2:0]  rsp_fault_kind
);
   import btld_pkg::*;

   parse_out_type evt;
   event_type     head;
   logic          accept;
   logic          full;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   // Parse each accepted transaction
   btld_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_in    (req_data_in),
      .buffer_end (req_buffer_end),
      .evt        (evt)
   );

   // Queue events toward the result channel
   btld_event_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .full       (full),
      .head_valid (rsp_valid),
      .head_stall (rsp_stall),
      .head       (head)
   );

   assign rsp_event_res     = head.event_res;
   assign rsp_entry_tag     = head.entry_tag;
   assign rsp_string_length = head.string_length;
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_string_done   = head.string_done;
   assign rsp_bytes_used    = head.bytes_used;
   assign rsp_fault_kind    = head.fault_kind;

endmodule
